### rtl/bps_pkg.sv
// bps_pkg: shared constants for the bus pause sequencer
// field widths, request codes, register indexes and phase codes
// no dependencies
package bps_pkg;

	// fixed field widths
	localparam int unsigned REQ_W   = 2;
	localparam int unsigned MS_W    = 32;
	localparam int unsigned PHASE_W = 4;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 32;

	// request codes
	localparam logic [REQ_W-1:0] REQ_POLL  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_START = 2'd1;
	localparam logic [REQ_W-1:0] REQ_STOP  = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_DURATION  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_PERIOD    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HANDLER_PRESENT = 2'd2;

	// phase codes
	localparam logic [PHASE_W-1:0] PH_STOPPING = 4'd0;
	localparam logic [PHASE_W-1:0] PH_STOPPED  = 4'd1;
	localparam logic [PHASE_W-1:0] PH_RUN      = 4'd2;
	localparam logic [PHASE_W-1:0] PH_START    = 4'd3;
	localparam logic [PHASE_W-1:0] PH_WAIT1    = 4'd4;
	localparam logic [PHASE_W-1:0] PH_HALF     = 4'd5;
	localparam logic [PHASE_W-1:0] PH_WAIT2    = 4'd6;
	localparam logic [PHASE_W-1:0] PH_TIMEOUT  = 4'd7;
	localparam logic [PHASE_W-1:0] PH_FINISH   = 4'd8;

	typedef logic [PHASE_W-1:0] phase_t;

endpackage

### rtl/bps_req_if.sv
// bps_req_if: request channel of the bus pause sequencer
// valid/ready handshake with the request payload; depends on bps_pkg
interface bps_req_if;
	logic                        valid;
	logic                        ready;
	logic [bps_pkg::REQ_W-1:0]   req_type;
	logic [bps_pkg::MS_W-1:0]    now_ms;
	logic                        upper_ready;
	logic [bps_pkg::MS_W-1:0]    arbiter_duration;

	modport source (output valid, req_type, now_ms, upper_ready, arbiter_duration,
		input ready);
	modport sink (input valid, req_type, now_ms, upper_ready, arbiter_duration,
		output ready);
endinterface

### rtl/bps_rsp_if.sv
// bps_rsp_if: result channel of the bus pause sequencer
// valid/ready handshake with the result payload; depends on bps_pkg
interface bps_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [bps_pkg::PHASE_W-1:0]   state_code;
	logic                          pause_busy;
	logic                          upper_consulted;
	logic                          timer_pause_begin;
	logic [bps_pkg::MS_W-1:0]      timer_duration;

	modport source (output valid, state_code, pause_busy, upper_consulted,
		timer_pause_begin, timer_duration, input ready);
	modport sink (input valid, state_code, pause_busy, upper_consulted,
		timer_pause_begin, timer_duration, output ready);
endinterface

### rtl/bus_pause_sequencer.sv
// bus_pause_sequencer: nine-phase pause controller for a bus MAC
// depends on bps_pkg, bps_req_if and bps_rsp_if
//
// Usage: each beat on the req channel is a poll step, a start command or a
// stop command; every request beat yields exactly one beat on the rsp channel
// with the new phase, the busy flag, whether the upper layer was consulted and
// the timer pause-start pulse with its duration.
// Configuration (pause duration, period, handler present) is written through
// cfg_we/cfg_index/cfg_data; the user must do so only while no beat is in flight
// (the block does not enforce this); writes take effect at once, unknown indexes are dropped.
// Pipeline: input register, then result register. Throughput: one beat per cycle
// while rsp.ready is held high; the phase update is one wrapping subtract and
// compare between the two registers, so consecutive beats follow each other
// with no bubble.
// Stall: a held result keeps its register; the input register still takes
// one more beat, after which req.ready drops until the result is taken.
// Reset: arst_n clears the phase to stopping, both time origins and all
// configuration registers to zero; no results are pending after reset.
module bus_pause_sequencer #(
	parameter int unsigned TIME_BITS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [bps_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bps_pkg::CFG_DATA_W-1:0]   cfg_data,
	bps_req_if.sink                          req,
	bps_rsp_if.source                        rsp
);

	// compare width covers both the time counter and the 32-bit limits
	localparam int unsigned CMP_W = (TIME_BITS > bps_pkg::MS_W) ? TIME_BITS : bps_pkg::MS_W;

	// configuration registers
	logic [bps_pkg::MS_W-1:0] pause_duration_q;
	logic [bps_pkg::MS_W-1:0] pause_period_q;
	logic                     handler_present_q;

	// block state
	bps_pkg::phase_t          phase_q;
	logic [TIME_BITS-1:0]     period_origin_q;
	logic [TIME_BITS-1:0]     duration_origin_q;

	// input register
	logic                        valid_s1;
	logic [bps_pkg::REQ_W-1:0]   req_type_s1;
	logic [bps_pkg::MS_W-1:0]    now_ms_s1;
	logic                        upper_ready_s1;
	logic [bps_pkg::MS_W-1:0]    arbiter_duration_s1;

	// result register
	logic                        valid_s2;
	bps_pkg::phase_t             state_code_s2;
	logic                        pause_busy_s2;
	logic                        upper_consulted_s2;
	logic                        timer_pause_begin_s2;
	logic [bps_pkg::MS_W-1:0]    timer_duration_s2;

	// next-state logic signals
	logic                  advance;
	logic [CMP_W-1:0]      now_c;
	logic [TIME_BITS-1:0]  now_t;
	logic [CMP_W-1:0]      period_elapsed;
	logic [CMP_W-1:0]      duration_elapsed;
	logic [CMP_W-1:0]      period_lim;
	logic [CMP_W-1:0]      duration_lim;
	logic [CMP_W-1:0]      half_lim;
	logic                  asks;
	logic                  consulted;
	logic                  granted;
	logic                  pulse;
	logic                  load_period;
	logic                  load_duration;
	bps_pkg::phase_t       phase_d;

	// handshake: input stage moves on when the result register is free
	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pause_duration_q  <= '0;
			pause_period_q    <= '0;
			handler_present_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bps_pkg::CFG_PAUSE_DURATION:  pause_duration_q  <= cfg_data;
				bps_pkg::CFG_PAUSE_PERIOD:    pause_period_q    <= cfg_data;
				bps_pkg::CFG_HANDLER_PRESENT: handler_present_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_type_s1         <= req.req_type;
			now_ms_s1           <= req.now_ms;
			upper_ready_s1      <= req.upper_ready;
			arbiter_duration_s1 <= req.arbiter_duration;
		end
	end

	// wrapping elapsed times, widened for the compare
	assign now_c            = CMP_W'(now_ms_s1);
	assign now_t            = now_c[TIME_BITS-1:0];
	assign period_elapsed   = CMP_W'(TIME_BITS'(now_t - period_origin_q));
	assign duration_elapsed = CMP_W'(TIME_BITS'(now_t - duration_origin_q));
	assign period_lim       = CMP_W'(pause_period_q);
	assign duration_lim     = CMP_W'(pause_duration_q);
	assign half_lim         = CMP_W'(pause_duration_q >> 1);

	// phases that ask the upper layer
	assign asks = (phase_q == bps_pkg::PH_STOPPING) || (phase_q == bps_pkg::PH_START) ||
		(phase_q == bps_pkg::PH_HALF) || (phase_q == bps_pkg::PH_TIMEOUT) ||
		(phase_q == bps_pkg::PH_FINISH);

	// phase transition for the item in the input register
	always_comb begin
		phase_d       = phase_q;
		consulted     = 1'b0;
		granted       = 1'b0;
		pulse         = 1'b0;
		load_period   = 1'b0;
		load_duration = 1'b0;
		unique case (req_type_s1)
			bps_pkg::REQ_START: phase_d = bps_pkg::PH_START;
			bps_pkg::REQ_STOP:  phase_d = bps_pkg::PH_STOPPING;
			bps_pkg::REQ_POLL: begin
				consulted = asks && handler_present_q;
				granted   = consulted && upper_ready_s1;
				unique case (phase_q)
					bps_pkg::PH_STOPPING: if (granted) phase_d = bps_pkg::PH_STOPPED;
					bps_pkg::PH_STOPPED: begin
						load_period   = 1'b1;
						load_duration = 1'b1;
					end
					bps_pkg::PH_RUN:
						if (period_elapsed > period_lim) phase_d = bps_pkg::PH_START;
					bps_pkg::PH_START: begin
						if (granted) begin
							load_duration = 1'b1;
							pulse         = 1'b1;
							phase_d       = bps_pkg::PH_WAIT1;
						end
					end
					bps_pkg::PH_WAIT1:
						if (duration_elapsed > half_lim) phase_d = bps_pkg::PH_HALF;
					bps_pkg::PH_HALF: if (granted) phase_d = bps_pkg::PH_WAIT2;
					bps_pkg::PH_WAIT2:
						if (duration_elapsed > duration_lim) phase_d = bps_pkg::PH_TIMEOUT;
					bps_pkg::PH_TIMEOUT: if (granted) phase_d = bps_pkg::PH_FINISH;
					bps_pkg::PH_FINISH: begin
						if (granted) begin
							if (pause_period_q == '0) begin
								phase_d = bps_pkg::PH_STOPPING;
							end else begin
								load_period = 1'b1;
								phase_d     = bps_pkg::PH_RUN;
							end
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// state update on each advancing beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q           <= bps_pkg::PH_STOPPING;
			period_origin_q   <= '0;
			duration_origin_q <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			if (load_period) period_origin_q <= now_t;
			if (load_duration) duration_origin_q <= now_t;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			state_code_s2        <= phase_d;
			pause_busy_s2        <= (phase_d != bps_pkg::PH_STOPPED) &&
				(phase_d != bps_pkg::PH_RUN);
			upper_consulted_s2   <= consulted;
			timer_pause_begin_s2 <= pulse;
			timer_duration_s2    <= pulse ? arbiter_duration_s1 : '0;
		end
	end

	assign rsp.valid             = valid_s2;
	assign rsp.state_code        = state_code_s2;
	assign rsp.pause_busy        = pause_busy_s2;
	assign rsp.upper_consulted   = upper_consulted_s2;
	assign rsp.timer_pause_begin = timer_pause_begin_s2;
	assign rsp.timer_duration    = timer_duration_s2;

	// pause start is only reported on entry to wait1
	a_pulse_wait1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && timer_pause_begin_s2 |-> state_code_s2 == bps_pkg::PH_WAIT1)
		else $error("pause start pulse without entry to wait1");

	// a duration is forwarded only with the pause start pulse
	a_duration_gated: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !timer_pause_begin_s2 |-> timer_duration_s2 == '0)
		else $error("timer duration without pause start");

	// the state moves only when a beat leaves the input stage
	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(phase_q))
		else $error("phase changed without an advancing beat");

	// both stages full and the result stalled blocks new beats
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !rsp.ready |-> !req.ready)
		else $error("request taken while both stages are full");

endmodule
